// ----- src/odo_pkg.sv -----
`timescale 1ns / 1ps

package odo_pkg;

    // Configuration register indexes
    localparam logic REG_DIST_PER_COUNT      = 1'b0;
    localparam logic REG_TURN_PER_COUNT_DIFF = 1'b1;

    // CORDIC datapath width and start vector (gain 0.60725293500888 in Q4.30)
    localparam int unsigned CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // One input word: the two wheel counter values
    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_counts;

    // One output word: the pose after the tick
    typedef struct packed {
        logic signed [47:0] pose_x;
        logic signed [47:0] pose_y;
        logic        [31:0] heading;
    } t_pose;

    // Arctangent of 2^-i in binary-angle units, rounded
    function automatic logic [31:0] odo_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/odo_stream_if.sv -----
`timescale 1ns / 1ps

interface odo_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/odo_smul.sv -----
`timescale 1ns / 1ps

// Radix-2 serial multiplier: one multiplier bit per cycle while i_step is high, product shifts in from the top
module odo_smul #(
    parameter int unsigned WA       = 32,
    parameter int unsigned WB       = 32,
    parameter bit          B_SIGNED = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_step,
    input  logic signed [WA-1:0]   i_a,
    input  logic        [WB-1:0]   i_b,
    output logic        [WA+WB:0]  o_prod
);
    localparam int unsigned CW = $clog2(WB + 1);

    logic signed [WA:0]   r_hi;
    logic        [WB-1:0] r_lo;
    logic signed [WA-1:0] r_a;
    logic        [CW-1:0] r_cnt;
    logic signed [WA:0]   addend;
    logic signed [WA:0]   sum;
    logic                 last;

    // Select the partial product; a signed multiplier's top bit weighs negative
    assign last = (r_cnt == CW'(WB - 1));
    always_comb begin
        if (!r_lo[0]) begin
            addend = '0;
        end else if (B_SIGNED && last) begin
            addend = -{r_a[WA-1], r_a};
        end else begin
            addend = {r_a[WA-1], r_a};
        end
        sum = r_hi + addend;
    end

    // Load operands, then add and shift one bit per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_load) begin
            r_hi <= '0;
            r_lo <= i_b;
            r_a  <= i_a;
        end else if (i_step) begin
            r_hi <= {sum[WA], sum[WA:1]};
            r_lo <= {sum[0], r_lo[WB-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};
endmodule

// ----- src/odo_cordic.sv -----
`timescale 1ns / 1ps

// Iterative rotation-mode CORDIC, one step per cycle
module odo_cordic #(
    parameter int unsigned STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [31:0]                         i_angle,
    output logic signed [odo_pkg::CORDIC_W-1:0] o_cos,
    output logic signed [odo_pkg::CORDIC_W-1:0] o_sin
);
    import odo_pkg::*;

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic                       r_flip;
    logic [5:0]                 r_i;
    logic signed [CORDIC_W-1:0] z_in;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] at;

    assign z_in = {{(CORDIC_W-32){i_angle[31]}}, i_angle};
    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = {{(CORDIC_W-32){1'b0}}, odo_atan(r_i[4:0])};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= 6'(STEPS);
        end else if (i_load) begin
            r_i <= '0;
        end else if (r_i < 6'(STEPS)) begin
            r_i <= r_i + 1'b1;
        end
        // Fold the angle into a quarter turn either side of zero
        if (i_load) begin
            r_x <= CORDIC_GAIN_Q30;
            r_y <= '0;
            if (z_in > 34'sd1073741824) begin
                r_z    <= z_in - 34'sd2147483648;
                r_flip <= 1'b1;
            end else if (z_in < -34'sd1073741824) begin
                r_z    <= z_in + 34'sd2147483648;
                r_flip <= 1'b1;
            end else begin
                r_z    <= z_in;
                r_flip <= 1'b0;
            end
        end else if (r_i < 6'(STEPS)) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_cos = r_flip ? -r_x : r_x;
    assign o_sin = r_flip ? -r_y : r_y;
endmodule

// ----- src/differential_drive_odometry.sv -----
`timescale 1ns / 1ps

// Differential-drive odometry.
// i_cnt carries one word per tick: the left and right wheel counter values.
// o_pose carries one word per tick: x, y (mm, POS_FRAC_BITS fraction bits)
// and the heading as a binary angle, all after this tick's update.
// Set dist_per_count and turn_per_count_diff over the write port while idle.
// From the accepting edge the tick runs through S_MUL1, S_MEAN, S_MUL2 and S_DONE.
// Two serial multiply phases (one multiplier bit per cycle) do the work:
// S_MUL1 for wheel travel and turn, S_MUL2 for the rotation of the travel.
// The CORDIC runs beside the first multiply and is hidden behind it.
// One tick is in flight at a time; the next word is taken only back in S_IDLE,
// after the output word of the last tick is written.
// The output word is registered; while the receiver stalls the finished word
// holds, and the next tick waits before updating the pose.
// Reset clears the pose, the heading, the previous counts, the configuration registers and the output valid.
module differential_drive_odometry #(
    parameter int unsigned CORDIC_STEPS  = 24,
    parameter int unsigned POS_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    odo_stream_if.sink   i_cnt,
    odo_stream_if.source o_pose,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import odo_pkg::*;

    localparam int unsigned TRAVEL_SHIFT = 24 - POS_FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MEAN, S_MUL2, S_DONE} t_state;

    t_state             r_state;
    logic [5:0]         r_cnt;
    logic [31:0]        r_dist;
    logic [31:0]        r_turn;
    logic [31:0]        r_prev_l;
    logic [31:0]        r_prev_r;
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic [31:0]        r_h;
    logic               r_ovalid;

    logic               accept;
    logic signed [31:0] dl;
    logic signed [31:0] dr;
    logic signed [32:0] ddiff;
    logic [64:0]        pl;
    logic [64:0]        pr;
    logic [65:0]        pt;
    logic [98:0]        px;
    logic [98:0]        py;
    logic signed [63:0] tl;
    logic signed [63:0] tr;
    logic signed [64:0] tsum;
    logic signed [63:0] mean;
    logic signed [CORDIC_W-1:0] cs;
    logic signed [CORDIC_W-1:0] sn;

    // Count deltas wrap in 32 bits
    assign accept = i_cnt.valid && (r_state == S_IDLE);
    assign dl     = i_cnt.data.left_count - r_prev_l;
    assign dr     = i_cnt.data.right_count - r_prev_r;
    assign ddiff  = {dr[31], dr} - {dl[31], dl};

    odo_smul #(.WA(32), .WB(32), .B_SIGNED(1'b0)) u_mul_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(accept),
        .i_step(r_state == S_MUL1), .i_a(dl), .i_b(r_dist), .o_prod(pl));
    odo_smul #(.WA(32), .WB(32), .B_SIGNED(1'b0)) u_mul_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(accept),
        .i_step(r_state == S_MUL1), .i_a(dr), .i_b(r_dist), .o_prod(pr));
    odo_smul #(.WA(33), .WB(32), .B_SIGNED(1'b0)) u_mul_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(accept),
        .i_step(r_state == S_MUL1), .i_a(ddiff), .i_b(r_turn), .o_prod(pt));

    odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(accept),
        .i_angle(r_h), .o_cos(cs), .o_sin(sn));

    // Scale travel to position units, average the wheels
    assign tl   = $signed(pl[63:0]) >>> TRAVEL_SHIFT;
    assign tr   = $signed(pr[63:0]) >>> TRAVEL_SHIFT;
    assign tsum = {tl[63], tl} + {tr[63], tr};
    assign mean = tsum[64:1];

    odo_smul #(.WA(64), .WB(CORDIC_W), .B_SIGNED(1'b1)) u_mul_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(r_state == S_MEAN),
        .i_step(r_state == S_MUL2), .i_a(mean), .i_b(cs), .o_prod(px));
    odo_smul #(.WA(64), .WB(CORDIC_W), .B_SIGNED(1'b1)) u_mul_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(r_state == S_MEAN),
        .i_step(r_state == S_MUL2), .i_a(mean), .i_b(sn), .o_prod(py));

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_turn <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIST_PER_COUNT:      r_dist <= i_cfg_data;
                REG_TURN_PER_COUNT_DIFF: r_turn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence one tick and hold the pose as the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_h      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Drop the word once taken, unless the next one lands now
            if (r_ovalid && o_pose.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prev_l <= i_cnt.data.left_count;
                        r_prev_r <= i_cnt.data.right_count;
                        r_cnt    <= '0;
                        r_state  <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(CORDIC_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_pose.ready) begin
                        r_x      <= r_x + $signed(px[77:30]);
                        r_y      <= r_y + $signed(py[77:30]);
                        r_h      <= r_h + pt[47:16];
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cnt.ready          = (r_state == S_IDLE);
    assign o_pose.valid         = r_ovalid;
    assign o_pose.data.pose_x   = r_x;
    assign o_pose.data.pose_y   = r_y;
    assign o_pose.data.heading  = r_h;
endmodule
